@@ hdl/life_pkg.sv @@
`timescale 1ns / 1ps

package life_pkg;

    localparam int ROW_BITS = 64;
    localparam int IDX_BITS = 6;
    localparam int OP_BITS  = 2;

    localparam logic [OP_BITS-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_READ   = 2'd1;
    localparam logic [OP_BITS-1:0] OP_STEP   = 2'd2;

    // neighbor counts that keep a live cell / bring a dead one to life
    localparam logic [3:0] N_SURVIVE = 4'd2;
    localparam logic [3:0] N_BIRTH   = 4'd3;

    typedef struct packed {
        logic [OP_BITS-1:0]  op;
        logic [IDX_BITS-1:0] row_index;
        logic [ROW_BITS-1:0] row_cells_in;
    } t_in_item;

    typedef struct packed {
        logic [ROW_BITS-1:0] row_cells_out;
        logic [OP_BITS-1:0]  op_echo;
    } t_out_item;

    typedef struct packed {
        logic item_accept;
        logic clr_wr;
        logic step_prime;
        logic step_load;
        logic step_run;
        logic step_finish;
    } t_dp_cmd;

    typedef struct packed {
        logic row_last;
        logic s1_valid;
    } t_dp_stat;

    // one generation of one row; columns outside the row count as dead
    function automatic logic [ROW_BITS-1:0] life_next_row(
        input logic [ROW_BITS-1:0] above,
        input logic [ROW_BITS-1:0] cur,
        input logic [ROW_BITS-1:0] below
    );
        logic [ROW_BITS+1:0] a_ext;
        logic [ROW_BITS+1:0] c_ext;
        logic [ROW_BITS+1:0] b_ext;
        logic [3:0]          n;
        logic [ROW_BITS-1:0] res;
        a_ext = {1'b0, above, 1'b0};
        c_ext = {1'b0, cur, 1'b0};
        b_ext = {1'b0, below, 1'b0};
        res   = '0;
        for (int c = 0; c < ROW_BITS; c++) begin
            n = 4'(a_ext[c]) + 4'(a_ext[c+1]) + 4'(a_ext[c+2])
              + 4'(c_ext[c]) + 4'(c_ext[c+2])
              + 4'(b_ext[c]) + 4'(b_ext[c+1]) + 4'(b_ext[c+2]);
            res[c] = cur[c] ? (n == N_SURVIVE || n == N_BIRTH) : (n == N_BIRTH);
        end
        return res;
    endfunction

endpackage

@@ hdl/life_generation_step.sv @@
`timescale 1ns / 1ps

// Bounded Game of Life grid, GRID_HEIGHT rows of GRID_WIDTH cells held in one
// single-port-read, single-port-write memory. Row write, row read and the unused
// op code are taken one per cycle while idle and the output slot is free; each
// gives its result in the cycle after it is accepted. A step scans the memory
// row by row through its one read port and one write port, reading row r+2
// while writing the new row r, and passes through the prime, load, run and done
// states before the next item is taken. After reset a clearing pass writes every
// row dead, with o_in_ready low. Rows from 64 up cannot be addressed but evolve.
module life_generation_step #(
    parameter int GRID_HEIGHT = 64,
    parameter int GRID_WIDTH  = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  life_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output life_pkg::t_out_item o_out
);
    import life_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    life_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_in.op),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    life_dp #(
        .GRID_HEIGHT (GRID_HEIGHT),
        .GRID_WIDTH  (GRID_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

@@ hdl/life_dp.sv @@
`timescale 1ns / 1ps

module life_dp #(
    parameter int GRID_HEIGHT = 64,
    parameter int GRID_WIDTH  = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  life_pkg::t_in_item  i_item,
    input  logic                i_out_ready,
    input  life_pkg::t_dp_cmd   i_cmd,
    output life_pkg::t_dp_stat  o_stat,
    output logic                o_out_valid,
    output life_pkg::t_out_item o_out
);
    import life_pkg::*;

    localparam int AW = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;

    logic [GRID_WIDTH-1:0] r_mem [GRID_HEIGHT];
    logic [GRID_WIDTH-1:0] r_rd_data;
    logic [ROW_BITS-1:0]   r_above;
    logic [ROW_BITS-1:0]   r_cur;
    logic [AW-1:0]         r_row;
    logic                  r_s1_valid;
    logic [OP_BITS-1:0]    r_s1_op;
    logic                  r_s1_hit;

    logic [AW+5:0]         idx_ext;
    logic                  idx_hit;
    logic [AW-1:0]         idx_addr;
    logic [AW:0]           row_plus1;
    logic [AW:0]           row_plus2;
    logic                  below_in;
    logic [ROW_BITS-1:0]   below;
    logic [ROW_BITS-1:0]   next_cells;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [GRID_WIDTH-1:0] wr_data;

    assign idx_ext   = (AW+6)'(i_item.row_index);
    assign idx_hit   = idx_ext < (AW+6)'(GRID_HEIGHT);
    assign idx_addr  = idx_ext[AW-1:0];
    assign row_plus1 = {1'b0, r_row} + (AW+1)'(1);
    assign row_plus2 = {1'b0, r_row} + (AW+1)'(2);
    assign below_in  = row_plus1 < (AW+1)'(GRID_HEIGHT);
    assign below     = below_in ? ROW_BITS'(r_rd_data) : '0;
    assign next_cells = life_next_row(r_above, r_cur, below);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = idx_addr;
        if (i_cmd.item_accept) begin
            rd_en = idx_hit && (i_item.op == OP_READ);
        end else if (i_cmd.step_prime) begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end else if (i_cmd.step_load) begin
            rd_en   = below_in;
            rd_addr = row_plus1[AW-1:0];
        end else if (i_cmd.step_run) begin
            rd_en   = row_plus2 < (AW+1)'(GRID_HEIGHT);
            rd_addr = row_plus2[AW-1:0];
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_row;
        wr_data = next_cells[GRID_WIDTH-1:0];
        if (i_cmd.item_accept) begin
            wr_en   = idx_hit && (i_item.op == OP_WRITE);
            wr_addr = idx_addr;
            wr_data = i_item.row_cells_in[GRID_WIDTH-1:0];
        end else if (i_cmd.clr_wr) begin
            wr_en   = 1'b1;
            wr_data = '0;
        end else if (i_cmd.step_run) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // scan window: old copies of the rows above and at the current position
    always_ff @(posedge i_clk) begin
        if (i_cmd.step_prime) begin
            r_above <= '0;
        end else if (i_cmd.step_load) begin
            r_cur <= ROW_BITS'(r_rd_data);
        end else if (i_cmd.step_run) begin
            r_above <= r_cur;
            r_cur   <= below;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else if (i_cmd.step_prime) begin
            r_row <= '0;
        end else if (i_cmd.clr_wr || i_cmd.step_run) begin
            r_row <= row_plus1[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_cmd.item_accept || i_cmd.step_finish) begin
            r_s1_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.item_accept) begin
            r_s1_op  <= i_item.op;
            r_s1_hit <= idx_hit;
        end else if (i_cmd.step_finish) begin
            r_s1_op  <= OP_STEP;
            r_s1_hit <= 1'b0;
        end
    end

    assign o_stat.row_last = (r_row == AW'(GRID_HEIGHT - 1));
    assign o_stat.s1_valid = r_s1_valid;

    assign o_out_valid       = r_s1_valid;
    assign o_out.op_echo     = r_s1_op;
    assign o_out.row_cells_out = (r_s1_op == OP_READ && r_s1_hit) ?
                                 ROW_BITS'(r_rd_data) : '0;

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !i_out_ready && !i_cmd.item_accept && !i_cmd.step_finish
        |=> r_s1_valid && $stable(r_s1_op))
        else $error("pending result lost while stalled");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step_run && o_stat.row_last |=> !i_cmd.step_run)
        else $error("step scan ran past the last row");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_wr |-> !r_s1_valid && !i_cmd.item_accept)
        else $error("item traffic during clearing pass");

endmodule

@@ hdl/life_ctrl.sv @@
`timescale 1ns / 1ps

module life_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic [life_pkg::OP_BITS-1:0]     i_op,
    input  logic                             i_out_ready,
    input  life_pkg::t_dp_stat               i_stat,
    output logic                             o_in_ready,
    output life_pkg::t_dp_cmd                o_cmd
);
    import life_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_PRIME = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_RUN   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;
    logic       slot_free;

    assign slot_free  = !i_stat.s1_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && slot_free;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.row_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_op == OP_STEP) begin
                        n_state = ST_PRIME;
                    end else begin
                        o_cmd.item_accept = 1'b1;
                    end
                end
            end
            ST_PRIME: begin
                o_cmd.step_prime = 1'b1;
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.step_load = 1'b1;
                n_state = ST_RUN;
            end
            ST_RUN: begin
                o_cmd.step_run = 1'b1;
                if (i_stat.row_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // step result waits for the output slot
                if (slot_free) begin
                    o_cmd.step_finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import life_pkg::*;

    localparam int GRID_DEPTH = 64;
    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int MAX_REPORTS = 40;

    typedef struct {
        t_in_item item;
        bit       drain_first;
    } t_grid_op;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    logic [ROW_BITS-1:0] life_grid [GRID_DEPTH];
    t_grid_op  op_backlog[$];
    t_out_item row_results_due[$];

    int  send_idle_pct = 38;
    int  recv_idle_pct = 72;
    int  hold_asked = 0;
    int  hold_served = 0;
    int  hold_left = 0;
    int  items_queued = 0;
    int  mismatch_count = 0;
    int  quiet_cycles = 0;
    bit  in_taken = 1'b0;

    life_generation_step #(
        .GRID_HEIGHT(GRID_DEPTH),
        .GRID_WIDTH (ROW_BITS)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_item)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // next generation of one row, neighbors past either edge are dead
    function automatic logic [ROW_BITS-1:0] evolve_row(
        input logic [ROW_BITS-1:0] up,
        input logic [ROW_BITS-1:0] mid,
        input logic [ROW_BITS-1:0] dn
    );
        logic [ROW_BITS-1:0] nxt;
        int c;
        int dc;
        int cnt;
        nxt = '0;
        for (c = 0; c < ROW_BITS; c++) begin
            cnt = 0;
            for (dc = -1; dc <= 1; dc++) begin
                if (c + dc >= 0 && c + dc < ROW_BITS) begin
                    cnt += int'(up[c+dc]) + int'(dn[c+dc]);
                    if (dc != 0) cnt += int'(mid[c+dc]);
                end
            end
            nxt[c] = (cnt == N_BIRTH) || (mid[c] && cnt == N_SURVIVE);
        end
        return nxt;
    endfunction

    task automatic advance_generation();
        logic [ROW_BITS-1:0] prev [GRID_DEPTH];
        logic [ROW_BITS-1:0] up;
        logic [ROW_BITS-1:0] dn;
        int r;
        prev = life_grid;
        for (r = 0; r < GRID_DEPTH; r++) begin
            up = (r > 0) ? prev[r-1] : '0;
            dn = (r < GRID_DEPTH - 1) ? prev[r+1] : '0;
            life_grid[r] = evolve_row(up, prev[r], dn);
        end
    endtask

    task automatic apply_grid_op(input t_in_item it);
        t_out_item res;
        res.row_cells_out = '0;
        res.op_echo = it.op;
        case (it.op)
            OP_WRITE: life_grid[it.row_index] = it.row_cells_in;
            OP_READ:  res.row_cells_out = life_grid[it.row_index];
            OP_STEP:  advance_generation();
            default: ;
        endcase
        row_results_due.push_back(res);
    endtask

    task automatic queue_op(
        input logic [OP_BITS-1:0]  op,
        input logic [IDX_BITS-1:0] idx,
        input logic [ROW_BITS-1:0] cells,
        input bit                  drain
    );
        t_grid_op g;
        g.item.op = op;
        g.item.row_index = idx;
        g.item.row_cells_in = cells;
        g.drain_first = drain;
        op_backlog.push_back(g);
        items_queued++;
    endtask

    function automatic logic [ROW_BITS-1:0] any_row();
        return {$urandom, $urandom};
    endfunction

    // mix of densities so patterns neither die at once nor saturate
    function automatic logic [ROW_BITS-1:0] seed_row();
        logic [ROW_BITS-1:0] v;
        case ($urandom_range(4))
            0: v = any_row();
            1: v = any_row() & any_row();
            2: v = any_row() & any_row() & any_row();
            3: v = ROW_BITS'(3'b111) << $urandom_range(ROW_BITS - 1);
            default: v = ROW_BITS'(2'b11) << $urandom_range(ROW_BITS - 2)
                       | {1'b1, {(ROW_BITS - 2){1'b0}}, 1'b1};
        endcase
        return v;
    endfunction

    task automatic add_random_burst();
        int base;
        int nrows;
        int nsteps;
        int k;
        if ($urandom_range(99) < 20) begin
            queue_op(OP_BITS'($urandom_range(3)), IDX_BITS'($urandom), any_row(), 1'b0);
        end else begin
            base = $urandom_range(GRID_DEPTH - 1);
            nrows = $urandom_range(1, 6);
            nsteps = $urandom_range(0, 3);
            for (k = 0; k < nrows; k++)
                queue_op(OP_WRITE, IDX_BITS'(base + k), seed_row(), 1'b0);
            for (k = 0; k < nsteps; k++)
                queue_op(OP_STEP, IDX_BITS'($urandom), any_row(),
                         k == 0 && $urandom_range(9) == 0);
            for (k = -1; k <= nrows; k++)
                queue_op(OP_READ, IDX_BITS'(base + k), any_row(), 1'b0);
        end
    endtask

    // sender
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (op_backlog.size() != 0
                && !(op_backlog[0].drain_first && row_results_due.size() != 0)
                && $urandom_range(99) >= send_idle_pct) begin
                in_item  <= op_backlog[0].item;
                in_valid <= 1'b1;
                op_backlog.delete(0);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver, with an occasional long hold-off to back the block up
    always @(negedge clk) begin
        if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_CYCLES;
            out_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result check first, then prediction of the item taken at this edge
    always @(posedge clk) begin
        t_out_item want;
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (row_results_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, actual op_echo %0d row %h",
                                 $time, out_item.op_echo, out_item.row_cells_out);
                end else begin
                    want = row_results_due.pop_front();
                    if (out_item.row_cells_out !== want.row_cells_out) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: row_cells_out expected %h actual %h",
                                     $time, want.row_cells_out, out_item.row_cells_out);
                    end
                    if (out_item.op_echo !== want.op_echo) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: op_echo expected %0d actual %0d",
                                     $time, want.op_echo, out_item.op_echo);
                    end
                end
            end
            if (in_valid && in_ready)
                apply_grid_op(in_item);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int r;
        int phase;
        int target;
        for (r = 0; r < GRID_DEPTH; r++)
            life_grid[r] = '0;

        // reset state, edge rows, full rows across a step
        queue_op(OP_READ,   6'd63, '1, 1'b0);
        queue_op(OP_WRITE,  6'd0,  '1, 1'b0);
        queue_op(OP_WRITE,  6'd63, '1, 1'b0);
        queue_op(OP_READ,   6'd0,  '0, 1'b0);
        queue_op(OP_READ,   6'd63, '0, 1'b0);
        queue_op(OP_STEP,   6'd17, '1, 1'b0);
        queue_op(OP_READ,   6'd0,  '0, 1'b0);
        queue_op(OP_READ,   6'd1,  '0, 1'b0);
        queue_op(OP_READ,   6'd63, '0, 1'b0);
        // unused op code changes nothing
        queue_op(OP_UNUSED, 6'd63, '1, 1'b0);
        // blinker flips to vertical
        queue_op(OP_WRITE,  6'd10, 64'h0000_0007_0000_0000, 1'b0);
        queue_op(OP_STEP,   6'd0,  '0, 1'b1);
        queue_op(OP_READ,   6'd9,  '0, 1'b0);
        queue_op(OP_READ,   6'd10, '0, 1'b0);
        queue_op(OP_READ,   6'd11, '0, 1'b0);
        // cells on both column edges
        queue_op(OP_WRITE,  6'd32, 64'h8000_0000_0000_0001, 1'b0);
        queue_op(OP_WRITE,  6'd31, 64'hc000_0000_0000_0003, 1'b0);
        queue_op(OP_STEP,   6'd45, 64'h5555_5555_5555_5555, 1'b0);
        queue_op(OP_READ,   6'd31, '0, 1'b0);
        queue_op(OP_READ,   6'd32, '0, 1'b0);
        queue_op(OP_READ,   6'd33, '0, 1'b0);
        queue_op(OP_UNUSED, 6'd0,  '0, 1'b0);
        queue_op(OP_STEP,   6'd63, '1, 1'b0);
        queue_op(OP_READ,   6'd5,  '0, 1'b0);

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 38; recv_idle_pct = 72; end
                1: begin send_idle_pct = 72; recv_idle_pct = 38; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            target = (phase + 1) * 570;
            while (items_queued < target)
                add_random_burst();
            if (phase != 0) begin
                while (op_backlog.size() > target - items_queued + 500)
                    @(posedge clk);
                hold_asked++;
            end
            while (op_backlog.size() != 0 || in_valid || row_results_due.size() != 0)
                @(posedge clk);
        end

        repeat (70) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
